// File: src/gpd_pkg.sv
// ============================================================================
// gpd_pkg : shared types, constants and decode helpers
// Frame and result types for the gamepad serial frame decoder, plus the
// button decode used when a frame's checksum matches.
// ============================================================================
package gpd_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned POS_W     = 4;   // holds 0 .. FRAME_LEN
    localparam int unsigned BTN_W     = 14;
    localparam int unsigned NUM_STICK = 4;
    localparam int unsigned SUM_W     = 7;

    localparam logic [7:0]       START_MARK = 8'h80;
    localparam logic [SUM_W-1:0] SUM_MASK   = 7'h7F;
    localparam logic [7:0]       STICK_REST = 8'd64;

    // frame positions with a role of their own
    localparam logic [POS_W-1:0] POS_BTN_HI   = 4'd1;
    localparam logic [POS_W-1:0] POS_LAST_SUM = 4'd6;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd7;
    localparam logic [POS_W-1:0] POS_FULL     = 4'd8;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [7:0]       left_horizontal;
        logic [7:0]       left_vertical;
        logic [7:0]       right_horizontal;
        logic [7:0]       right_vertical;
        logic             frame_accepted;
        logic             timed_out;
    } result_t;

    // b1 carries square and the shoulder buttons, b2 the d-pad and symbols;
    // both bits of a d-pad pair set means start (vertical) or select (horizontal)
    function automatic logic [BTN_W-1:0] decode_buttons(input logic [7:0] b1,
                                                        input logic [7:0] b2);
        logic [BTN_W-1:0] bits;
        bits = '0;
        if (b2[1:0] == 2'b11)
            bits[12] = 1'b1;
        else if (b2[0])
            bits[0] = 1'b1;
        else if (b2[1])
            bits[1] = 1'b1;
        if (b2[3:2] == 2'b11)
            bits[13] = 1'b1;
        else if (b2[2])
            bits[2] = 1'b1;
        else if (b2[3])
            bits[3] = 1'b1;
        bits[4]  = b2[4];
        bits[5]  = b2[5];
        bits[6]  = b2[6];
        bits[7]  = b1[0];
        bits[8]  = b1[1];
        bits[9]  = b1[2];
        bits[10] = b1[3];
        bits[11] = b1[4];
        return bits;
    endfunction

endpackage

// File: src/gpd_in_stage.sv
// ============================================================================
// gpd_in_stage : input register
// Captures one transfer from the input channel and holds it until the
// frame core consumes it.
// ============================================================================
module gpd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gpd_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output gpd_pkg::item_t item
);
    import gpd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/gpd_frame_core.sv
// ============================================================================
// gpd_frame_core : frame tracking, checksum and held controller state
// Updates position, running checksum, stored bytes and held state for
// one item per cycle while step is high, and forms that item's result.
// ============================================================================
module gpd_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  gpd_pkg::item_t   item,
    output gpd_pkg::result_t result
);
    import gpd_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             armed_reg;
    logic             armed_next;
    logic [BTN_W-1:0] buttons_reg;
    logic [BTN_W-1:0] buttons_next;
    logic [7:0]       stick_reg  [NUM_STICK];
    logic [7:0]       stick_next [NUM_STICK];
    logic [7:0]       frame_reg  [1:6];

    logic             is_byte;
    logic [POS_W-1:0] pos_eff;
    logic             store;
    logic             match;
    logic             expire;

    assign is_byte = (item.opcode == OP_BYTE);
    assign pos_eff = (item.data_byte == START_MARK) ? '0 : pos_reg;
    assign store   = is_byte && (pos_eff < POS_FULL);
    assign match   = store && (pos_eff == POS_CHECK)
                     && (item.data_byte == {1'b0, sum_reg});
    assign expire  = !is_byte && armed_reg;

    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        armed_next   = armed_reg;
        buttons_next = buttons_reg;
        for (int k = 0; k < NUM_STICK; k++)
        begin
            stick_next[k] = stick_reg[k];
        end
        if (is_byte)
        begin
            pos_next = store ? pos_eff + POS_W'(1) : pos_eff;
        end
        // running 7-bit checksum over bytes 1 to 6
        if (store && pos_eff == POS_BTN_HI)
        begin
            sum_next = item.data_byte[SUM_W-1:0];
        end
        else if (store && pos_eff > POS_BTN_HI && pos_eff <= POS_LAST_SUM)
        begin
            sum_next = (sum_reg + item.data_byte[SUM_W-1:0]) & SUM_MASK;
        end
        if (match)
        begin
            armed_next    = 1'b0;
            buttons_next  = decode_buttons(frame_reg[1], frame_reg[2]);
            stick_next[0] = frame_reg[3];
            stick_next[1] = frame_reg[4];
            stick_next[2] = frame_reg[5];
            stick_next[3] = frame_reg[6];
        end
        else if (!is_byte)
        begin
            armed_next = 1'b1;
            if (expire)
            begin
                buttons_next = '0;
                for (int k = 0; k < NUM_STICK; k++)
                begin
                    stick_next[k] = STICK_REST;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            armed_reg   <= 1'b0;
            buttons_reg <= '0;
            for (int k = 0; k < NUM_STICK; k++)
            begin
                stick_reg[k] <= STICK_REST;
            end
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            armed_reg   <= armed_next;
            buttons_reg <= buttons_next;
            for (int k = 0; k < NUM_STICK; k++)
            begin
                stick_reg[k] <= stick_next[k];
            end
        end
    end

    // bytes 0 and 7 are never read back, so only 1 to 6 are kept
    for (genvar i = 1; i <= 6; i++)
    begin : g_frame
        always_ff @(posedge clk)
        begin
            if (step && store && pos_eff == POS_W'(i))
            begin
                frame_reg[i] <= item.data_byte;
            end
        end
    end

    always_comb
    begin
        result.buttons          = buttons_next;
        result.left_horizontal  = stick_next[0];
        result.left_vertical    = stick_next[1];
        result.right_horizontal = stick_next[2];
        result.right_vertical   = stick_next[3];
        result.frame_accepted   = match;
        result.timed_out        = expire;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("frame position beyond full frame");

    a_match_effect: assert property (@(posedge clk) disable iff (!rst_n)
        step && match |=> !armed_reg && pos_reg == POS_FULL)
        else $error("matched frame did not disarm timeout or finish frame");

    a_expire_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && expire |=> armed_reg && buttons_reg == '0
                           && stick_reg[0] == STICK_REST)
        else $error("timeout did not clear held state");

    a_tick_holds_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && !is_byte |=> $stable(pos_reg) && $stable(sum_reg))
        else $error("tick disturbed frame tracking");

endmodule

// File: src/gpd_out_stage.sv
// ============================================================================
// gpd_out_stage : result register
// Holds one finished result until the output channel takes it.
// ============================================================================
module gpd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    output logic             can_load,
    input  gpd_pkg::result_t result_in,
    output logic             out_valid,
    input  logic             out_ready,
    output gpd_pkg::result_t result_out
);
    import gpd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = can_load ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// File: src/gamepad_serial_frame_decoder.sv
// ============================================================================
// gamepad_serial_frame_decoder : 8-byte gamepad frame decoder
// Path: an input transfer is captured in the input register; the frame core
// then forms its result, which is held in the result register until taken.
// Throughput: one item per cycle unless out_ready stalls the result register;
// input register -> frame core -> result register, the core stepping on take.
// Reset (rst_n low, asynchronous): both stages empty, frame position 0,
// timeout disarmed, buttons 0 and all sticks at rest (64).
// ============================================================================
module gamepad_serial_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] buttons,
    output logic [7:0]  left_horizontal,
    output logic [7:0]  left_vertical,
    output logic [7:0]  right_horizontal,
    output logic [7:0]  right_vertical,
    output logic        frame_accepted,
    output logic        timed_out
);
    import gpd_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    take;
    result_t core_result;
    result_t result;

    // pack the input ports into one item
    assign in_item.opcode    = opcode_t'(opcode);
    assign in_item.data_byte = data_byte;

    // advance the held item into the core whenever the result register has
    // room: it is either empty or its transfer completes this cycle
    assign take = item_valid && can_load;

    gpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // frame state moves only on the cycle its item advances
    gpd_frame_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (item),
        .result (core_result)
    );

    gpd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .can_load   (can_load),
        .result_in  (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result)
    );

    // unpack the held result onto the output ports
    assign buttons          = result.buttons;
    assign left_horizontal  = result.left_horizontal;
    assign left_vertical    = result.left_vertical;
    assign right_horizontal = result.right_horizontal;
    assign right_vertical   = result.right_vertical;
    assign frame_accepted   = result.frame_accepted;
    assign timed_out        = result.timed_out;

endmodule
